FILE: hdl/mfs_pkg.sv
// Shared types and codes for the multilevel feedback scheduler.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package mfs_pkg;

    localparam logic [1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_AGE      = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic CFG_QUANTUM   = 1'b0;
    localparam logic CFG_AGE_LIMIT = 1'b1;

    localparam logic [15:0] QUANTUM_RESET   = 16'd100;
    localparam logic [15:0] AGE_LIMIT_RESET = 16'd1000;

    localparam logic [1:0] LEVEL_TOP    = 2'd0;
    localparam logic [1:0] LEVEL_SECOND = 2'd1;
    localparam logic [1:0] LEVEL_BOTTOM = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  task_id;
        logic [1:0]  start_level;
        logic [15:0] burst_len;
        logic [31:0] now;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  run_id;
        logic [1:0]  run_level;
        logic [15:0] grant;
        logic        finished;
        logic [2:0]  promoted;
    } out_t;

    typedef struct packed {
        logic       accept;
        logic       clear;
        logic       scan;
        logic       apply;
        logic [1:0] level;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic       last;
        logic [1:0] op;
    } sts_t;

endpackage
`default_nettype wire

FILE: hdl/multilevel_feedback_scheduler_unit.sv
// Top level of the four-level feedback queue scheduler with aging.
// Instantiates mfs_ctrl and mfs_dp; types from mfs_pkg.
//
// One operation is taken at a time. Enqueue and dispatch each scan every task
// slot once through the single read port of the slot memory; an aging tick
// scans once per level it checks. An ignored opcode is passed straight to the
// result without a scan. The result sits in an output register, so it may wait
// there while the next operation is worked on. Configuration writes take
// effect at once.
`default_nettype none
module multilevel_feedback_scheduler_unit #(
    parameter int SLOTS = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          task_valid,
    output logic               task_stall,
    input  wire mfs_pkg::in_t  task_data,
    output logic               result_valid,
    input  wire logic          result_stall,
    output mfs_pkg::out_t      result_data,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [15:0]   cfg_data
);
    import mfs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mfs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_stall   (task_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .task_op      (task_data.op),
        .sts          (sts),
        .cmd          (cmd)
    );

    mfs_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .task_data   (task_data),
        .result_data (result_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

endmodule
`default_nettype wire

FILE: hdl/mfs_ctrl.sv
// Sequencer of the scheduler: handshakes, slot scan passes and write-back.
// Depends on mfs_pkg for command and status types.
`default_nettype none
module mfs_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        task_valid,
    output logic             task_stall,
    output logic             result_valid,
    input  wire logic        result_stall,
    input  wire logic [1:0]  task_op,
    input  wire mfs_pkg::sts_t sts,
    output mfs_pkg::cmd_t    cmd
);
    import mfs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] level_reg, level_next;
    logic       out_valid_reg, out_valid_next;

    assign task_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg && result_stall;
        cmd            = '0;
        cmd.level      = level_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (task_valid)
                begin
                    cmd.accept = 1'b1;
                    if (task_op == OP_NONE)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        level_next = (task_op == OP_AGE) ? LEVEL_SECOND : LEVEL_TOP;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                if (sts.op == OP_AGE && level_reg != LEVEL_BOTTOM)
                begin
                    cmd.clear  = 1'b1;
                    level_next = level_reg + 2'd1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= LEVEL_TOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/mfs_dp.sv
// Datapath of the scheduler: slot memory, valid bits, per-level best search,
// order counter, configuration registers and result registers. Uses mfs_pkg.
`default_nettype none
module mfs_dp #(
    parameter int SLOTS = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mfs_pkg::cmd_t  cmd,
    output mfs_pkg::sts_t       sts,
    input  wire mfs_pkg::in_t   task_data,
    output mfs_pkg::out_t       result_data,
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [15:0]    cfg_data
);
    import mfs_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [1:0]  level;
        logic [15:0] remaining;
        logic [31:0] stamp;
        logic [31:0] order;
    } slot_t;

    slot_t mem [SLOTS];
    slot_t rd_q;

    logic [SLOTS-1:0] valid_reg;
    logic [31:0]      counter_reg;
    logic [15:0]      quantum_reg, age_limit_reg;
    in_t              item_reg;
    out_t             res_reg, out_reg;
    logic [IDX_W-1:0] idx_reg, rd_idx_q;
    logic             rd_valid_q;

    logic [3:0]       found_reg;
    logic [IDX_W-1:0] bidx_reg [4];
    slot_t            best_reg [4];
    logic [31:0]      bage_reg [4];
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic [3:0]  better;
    logic [31:0] cur_age;
    logic        cur_valid;

    logic             we;
    logic [IDX_W-1:0] wa;
    slot_t            wd;
    logic             counter_inc;
    logic             valid_set, valid_clr;

    logic        any_found;
    logic [1:0]  dlev;
    slot_t       dsel;
    logic [15:0] grant;
    logic        fin;
    slot_t       asel;
    logic        age_ok;

    assign sts.last    = (idx_reg == IDX_W'(SLOTS - 1));
    assign sts.op      = item_reg.op;
    assign result_data = out_reg;

    assign cur_valid = rd_valid_q && valid_reg[rd_idx_q];
    assign cur_age   = counter_reg - rd_q.order;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (l == 0 || l == 3)
            begin
                better[l] = !found_reg[l] || (cur_age > bage_reg[l]);
            end
            else
            begin
                better[l] = !found_reg[l] ||
                            (rd_q.remaining < best_reg[l].remaining) ||
                            (rd_q.remaining == best_reg[l].remaining &&
                             rd_q.task_id < best_reg[l].task_id);
            end
            better[l] = better[l] && cur_valid && (rd_q.level == 2'(l));
        end
    end

    always_comb
    begin
        any_found = |found_reg;
        dlev      = found_reg[0] ? 2'd0 : found_reg[1] ? 2'd1 :
                    found_reg[2] ? 2'd2 : 2'd3;
        dsel      = best_reg[dlev];
        grant     = (dlev == LEVEL_TOP && quantum_reg < dsel.remaining) ?
                    quantum_reg : dsel.remaining;
        fin       = (grant == dsel.remaining);
        asel      = best_reg[cmd.level];
        age_ok    = found_reg[cmd.level] &&
                    ((item_reg.now - asel.stamp) >= {16'd0, age_limit_reg});
    end

    always_comb
    begin
        we          = 1'b0;
        wa          = free_idx_reg;
        wd          = '{task_id: item_reg.task_id, level: item_reg.start_level,
                        remaining: item_reg.burst_len, stamp: item_reg.now,
                        order: counter_reg};
        counter_inc = 1'b0;
        valid_set   = 1'b0;
        valid_clr   = 1'b0;
        if (cmd.apply)
        begin
            case (item_reg.op)
                OP_ENQUEUE:
                begin
                    if (free_found_reg)
                    begin
                        we          = 1'b1;
                        valid_set   = 1'b1;
                        counter_inc = 1'b1;
                    end
                end
                OP_DISPATCH:
                begin
                    wa = bidx_reg[dlev];
                    wd = dsel;
                    wd.remaining = dsel.remaining - grant;
                    wd.order     = counter_reg;
                    if (any_found)
                    begin
                        if (fin)
                        begin
                            valid_clr = 1'b1;
                        end
                        else
                        begin
                            we          = 1'b1;
                            counter_inc = 1'b1;
                        end
                    end
                end
                OP_AGE:
                begin
                    wa = bidx_reg[cmd.level];
                    wd = asel;
                    wd.level = cmd.level - 2'd1;
                    wd.stamp = item_reg.now;
                    wd.order = counter_reg;
                    if (age_ok)
                    begin
                        we          = 1'b1;
                        counter_inc = 1'b1;
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.scan)
        begin
            rd_q <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            counter_reg    <= '0;
            quantum_reg    <= QUANTUM_RESET;
            age_limit_reg  <= AGE_LIMIT_RESET;
            rd_valid_q     <= 1'b0;
            idx_reg        <= '0;
            found_reg      <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUANTUM:   quantum_reg   <= cfg_data;
                    CFG_AGE_LIMIT: age_limit_reg <= cfg_data;
                    default:       quantum_reg   <= quantum_reg;
                endcase
            end
            if (valid_set)
            begin
                valid_reg[wa] <= 1'b1;
            end
            if (valid_clr)
            begin
                valid_reg[wa] <= 1'b0;
            end
            if (counter_inc)
            begin
                counter_reg <= counter_reg + 32'd1;
            end
            rd_valid_q <= cmd.scan;
            if (cmd.clear)
            begin
                idx_reg        <= '0;
                found_reg      <= '0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                for (int l = 0; l < 4; l++)
                begin
                    if (better[l])
                    begin
                        found_reg[l] <= 1'b1;
                    end
                end
                if (rd_valid_q && !valid_reg[rd_idx_q] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_q <= idx_reg;
        for (int l = 0; l < 4; l++)
        begin
            if (better[l])
            begin
                best_reg[l] <= rd_q;
                bidx_reg[l] <= rd_idx_q;
                bage_reg[l] <= cur_age;
            end
        end
        if (rd_valid_q && !valid_reg[rd_idx_q] && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_q;
        end
        if (cmd.accept)
        begin
            item_reg <= task_data;
            res_reg  <= '0;
        end
        if (cmd.apply)
        begin
            case (item_reg.op)
                OP_ENQUEUE:
                begin
                    res_reg.status <= free_found_reg ? ST_DONE : ST_FULL;
                end
                OP_DISPATCH:
                begin
                    if (any_found)
                    begin
                        res_reg.run_id    <= dsel.task_id;
                        res_reg.run_level <= dlev;
                        res_reg.grant     <= grant;
                        res_reg.finished  <= fin;
                    end
                    else
                    begin
                        res_reg.status <= ST_EMPTY;
                    end
                end
                OP_AGE:
                begin
                    if (age_ok)
                    begin
                        res_reg.promoted[2'(cmd.level - 2'd1)] <= 1'b1;
                    end
                end
                default:
                begin
                    res_reg <= res_reg;
                end
            endcase
        end
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

endmodule
`default_nettype wire
